### rtl/core/hsat_pkg.sv
// ----------------------------------------------------------------------------
// hsat_pkg: shared types and constants for the Helmert transform
// Coordinate, rotation and accumulator widths, payload words, direction codes.
// ----------------------------------------------------------------------------
package hsat_pkg;

	function automatic int imax(input int a, input int b);
		return (a > b) ? a : b;
	endfunction

	// number formats
	localparam int COORD_BITS = 40;
	localparam int FRAC_BITS  = 40;
	localparam int ROT_W      = 32;
	localparam int SHIFT_W    = 31;
	localparam int FRAME_W    = 8;

	// config port
	localparam int CFG_DATA_W = 32;
	localparam int REG_IDX_W  = 3;

	localparam logic [REG_IDX_W-1:0] REG_FRAME_PAIR  = 3'd0;
	localparam logic [REG_IDX_W-1:0] REG_ROT_X       = 3'd1;
	localparam logic [REG_IDX_W-1:0] REG_ROT_Y       = 3'd2;
	localparam logic [REG_IDX_W-1:0] REG_ROT_Z       = 3'd3;
	localparam logic [REG_IDX_W-1:0] REG_SCALE_DELTA = 3'd4;
	localparam logic [REG_IDX_W-1:0] REG_SHIFT_X     = 3'd5;
	localparam logic [REG_IDX_W-1:0] REG_SHIFT_Y     = 3'd6;
	localparam logic [REG_IDX_W-1:0] REG_SHIFT_Z     = 3'd7;

	// direction codes
	localparam logic [1:0] DIR_FWD  = 2'd0;
	localparam logic [1:0] DIR_INV  = 2'd1;
	localparam logic [1:0] DIR_NONE = 2'd2;

	// multiplier split: low part unsigned, high part signed
	localparam int SPLIT_W = 16;
	localparam int HI_W    = COORD_BITS - SPLIT_W;
	localparam int PROD_W  = ROT_W + COORD_BITS;            // scale * v
	localparam int RND_W   = PROD_W + 1 - FRAC_BITS;        // round(scale * v)
	localparam int U_W     = imax(imax(COORD_BITS, RND_W), SHIFT_W) + 2;
	localparam int UHI_W   = U_W - SPLIT_W;
	localparam int XP_W    = ROT_W + U_W + 1;               // cross term
	localparam int ACC_W   = imax(imax(U_W + FRAC_BITS, PROD_W),
		imax(SHIFT_W + FRAC_BITS, XP_W)) + 3;
	localparam int Q_W     = ACC_W + 1 - FRAC_BITS;

	// edges from the accepting edge to the edge that ends the strobe cycle
	localparam int PIPE_DEPTH = 7;

	typedef logic signed [COORD_BITS-1:0] coord_t;
	typedef logic signed [ROT_W-1:0]      rot_t;
	typedef logic signed [SHIFT_W-1:0]    shift_t;
	typedef logic signed [U_W-1:0]        u_t;
	typedef logic signed [ACC_W-1:0]      acc_t;

	localparam coord_t COORD_MAX = {1'b0, {(COORD_BITS-1){1'b1}}};
	localparam coord_t COORD_MIN = {1'b1, {(COORD_BITS-1){1'b0}}};

	typedef struct packed {
		coord_t               in_x;
		coord_t               in_y;
		coord_t               in_z;
		logic [FRAME_W-1:0]   src_frame;
	} in_word_t;

	typedef struct packed {
		coord_t     out_x;
		coord_t     out_y;
		coord_t     out_z;
		logic [1:0] direction;
		logic       saturated;
	} out_word_t;

	typedef struct packed {
		logic       vld;
		logic [1:0] dir;
	} ctl_t;

endpackage

### rtl/core/hsat_lane.sv
// ----------------------------------------------------------------------------
// hsat_lane: per-axis scale stage
// Forms scale*v in two registered partial products, then the rotation
// operand u and the axis-local accumulator part.
// ----------------------------------------------------------------------------
module hsat_lane (
	input  logic             clk,
	input  hsat_pkg::coord_t v,       // s1
	input  logic             inv,     // aligned with s2
	input  hsat_pkg::rot_t   scale,
	input  hsat_pkg::shift_t shift,
	output hsat_pkg::u_t     u_s3,
	output hsat_pkg::acc_t   base_s3
);

	logic signed [hsat_pkg::ROT_W+hsat_pkg::HI_W-1:0] ph_s2;
	logic signed [hsat_pkg::ROT_W+hsat_pkg::SPLIT_W:0] pl_s2;
	hsat_pkg::coord_t                                  v_s2;
	logic signed [hsat_pkg::PROD_W-1:0]                sv;
	logic [hsat_pkg::PROD_W:0]                         sv_r;
	logic signed [hsat_pkg::RND_W-1:0]                 rnd;
	hsat_pkg::u_t                                      u_d;
	hsat_pkg::acc_t                                    base_d;

	always_ff @(posedge clk) begin
		ph_s2 <= scale * $signed(v[hsat_pkg::COORD_BITS-1:hsat_pkg::SPLIT_W]);
		pl_s2 <= scale * $signed({1'b0, v[hsat_pkg::SPLIT_W-1:0]});
		v_s2  <= v;
	end

	always_comb begin
		sv   = $signed({ph_s2, {hsat_pkg::SPLIT_W{1'b0}}})
			+ hsat_pkg::PROD_W'(pl_s2);
		// round half up
		sv_r = (hsat_pkg::PROD_W+1)'(sv)
			+ ((hsat_pkg::PROD_W+1)'(1) << (hsat_pkg::FRAC_BITS-1));
		rnd  = sv_r[hsat_pkg::PROD_W:hsat_pkg::FRAC_BITS];
		if (inv) begin
			u_d    = hsat_pkg::U_W'(v_s2) - hsat_pkg::U_W'(rnd)
				- hsat_pkg::U_W'(shift);
			base_d = '0;
		end else begin
			u_d    = hsat_pkg::U_W'(v_s2);
			base_d = hsat_pkg::ACC_W'(sv)
				+ (hsat_pkg::ACC_W'(shift) << hsat_pkg::FRAC_BITS);
		end
	end

	always_ff @(posedge clk) begin
		u_s3    <= u_d;
		base_s3 <= base_d;
	end

endmodule

### rtl/core/hsat_merge.sv
// ----------------------------------------------------------------------------
// hsat_merge: cross-axis rotation, accumulate, round and clamp
// Combines the three lane results through the skew rotation terms and
// drives the result word and its strobe.
// ----------------------------------------------------------------------------
module hsat_merge (
	input  logic                clk,
	input  logic                arst_n,
	input  hsat_pkg::ctl_t      ctl_s3,
	input  hsat_pkg::u_t        u_s3 [3],
	input  hsat_pkg::acc_t      base_s3 [3],
	input  hsat_pkg::rot_t      rot [3],
	output logic                done,
	output hsat_pkg::out_word_t res
);

	hsat_pkg::ctl_t      ctl_s4, ctl_s5, ctl_s6;
	logic                done_q;
	hsat_pkg::out_word_t res_q;
	hsat_pkg::coord_t    clip [3];
	logic [2:0]          ovf;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s4 <= '0;
			ctl_s5 <= '0;
			ctl_s6 <= '0;
			done_q <= 1'b0;
		end else begin
			ctl_s4 <= ctl_s3;
			ctl_s5 <= ctl_s4;
			ctl_s6 <= ctl_s5;
			done_q <= ctl_s6.vld;
		end
	end

	// axis i: r[i+1]*u[i+2] - r[i+2]*u[i+1]; inverse takes the negation
	for (genvar i = 0; i < 3; i++) begin : g_axis
		localparam int J = (i + 1) % 3;
		localparam int K = (i + 2) % 3;

		logic signed [hsat_pkg::ROT_W+hsat_pkg::UHI_W-1:0]  ah_s4, bh_s4;
		logic signed [hsat_pkg::ROT_W+hsat_pkg::SPLIT_W:0]  al_s4, bl_s4;
		hsat_pkg::u_t                                       u_s4, u_s5;
		hsat_pkg::acc_t                                     base_s4, base_s5;
		logic signed [hsat_pkg::XP_W-1:0]                   pa, pb, cross_s5;
		hsat_pkg::acc_t                                     acc_s6;
		logic [hsat_pkg::ACC_W:0]                           acc_r;
		logic signed [hsat_pkg::Q_W-1:0]                    q;
		logic [hsat_pkg::Q_W-hsat_pkg::COORD_BITS:0]        q_hi;

		always_ff @(posedge clk) begin
			ah_s4   <= rot[J] * $signed(u_s3[K][hsat_pkg::U_W-1:hsat_pkg::SPLIT_W]);
			al_s4   <= rot[J] * $signed({1'b0, u_s3[K][hsat_pkg::SPLIT_W-1:0]});
			bh_s4   <= rot[K] * $signed(u_s3[J][hsat_pkg::U_W-1:hsat_pkg::SPLIT_W]);
			bl_s4   <= rot[K] * $signed({1'b0, u_s3[J][hsat_pkg::SPLIT_W-1:0]});
			u_s4    <= u_s3[i];
			base_s4 <= base_s3[i];
		end

		assign pa = hsat_pkg::XP_W'($signed({ah_s4, {hsat_pkg::SPLIT_W{1'b0}}}))
			+ hsat_pkg::XP_W'(al_s4);
		assign pb = hsat_pkg::XP_W'($signed({bh_s4, {hsat_pkg::SPLIT_W{1'b0}}}))
			+ hsat_pkg::XP_W'(bl_s4);

		always_ff @(posedge clk) begin
			cross_s5 <= (ctl_s4.dir == hsat_pkg::DIR_INV) ? (pb - pa) : (pa - pb);
			u_s5     <= u_s4;
			base_s5  <= base_s4;
			acc_s6   <= (hsat_pkg::ACC_W'(u_s5) << hsat_pkg::FRAC_BITS) + base_s5
				+ hsat_pkg::ACC_W'(cross_s5);
		end

		assign acc_r = (hsat_pkg::ACC_W+1)'(acc_s6)
			+ ((hsat_pkg::ACC_W+1)'(1) << (hsat_pkg::FRAC_BITS-1));
		assign q      = acc_r[hsat_pkg::ACC_W:hsat_pkg::FRAC_BITS];
		assign q_hi   = q[hsat_pkg::Q_W-1:hsat_pkg::COORD_BITS-1];
		assign ovf[i] = !((&q_hi) || !(|q_hi));
		assign clip[i] = ovf[i]
			? (q[hsat_pkg::Q_W-1] ? hsat_pkg::COORD_MIN : hsat_pkg::COORD_MAX)
			: q[hsat_pkg::COORD_BITS-1:0];
	end

	always_ff @(posedge clk) begin
		if (ctl_s6.dir == hsat_pkg::DIR_NONE) begin
			res_q.out_x     <= '0;
			res_q.out_y     <= '0;
			res_q.out_z     <= '0;
			res_q.saturated <= 1'b0;
		end else begin
			res_q.out_x     <= clip[0];
			res_q.out_y     <= clip[1];
			res_q.out_z     <= clip[2];
			res_q.saturated <= |ovf;
		end
		res_q.direction <= ctl_s6.dir;
	end

	assign done = done_q;
	assign res  = res_q;

endmodule

### rtl/core/helmert_small_angle_transform.sv
// ----------------------------------------------------------------------------
// helmert_small_angle_transform: 7-parameter Helmert transform, small angles
// Forward or inverse transform of one Cartesian point, chosen by frame id.
// ----------------------------------------------------------------------------
// Takes one point per clock, every clock: busy is always low and the
// pipeline never stalls. A word accepted at a clock edge (start high) passes
// through seven registers, the first loaded at the accepting edge; done and
// the word on res come from the last of them, loaded at the same edge, and
// done marks each result word. The seven stages are input decode,
// two for scale*v, two for the rotation cross terms, the final accumulate,
// and round/clamp into the output register. There is no backpressure: the
// receiver must take every done word. Config writes (cfg_ready is always
// high) take effect at once, so write only while nothing is in flight.
module helmert_small_angle_transform (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                start,
	output logic                                busy,
	input  hsat_pkg::in_word_t                  cmd,
	output logic                                done,
	output hsat_pkg::out_word_t                 res,
	input  logic                                cfg_valid,
	output logic                                cfg_ready,
	input  logic [hsat_pkg::REG_IDX_W-1:0]      cfg_index,
	input  logic [hsat_pkg::CFG_DATA_W-1:0]     cfg_data
);

	// config registers
	logic [2*hsat_pkg::FRAME_W-1:0] frame_pair_q;
	hsat_pkg::rot_t                 rot_q [3];
	hsat_pkg::rot_t                 scale_q;
	hsat_pkg::shift_t               shift_q [3];

	// stage 1: decode
	hsat_pkg::ctl_t   ctl_d, ctl_s1, ctl_s2, ctl_s3;
	hsat_pkg::coord_t v_s1 [3];
	hsat_pkg::u_t     u_s3 [3];
	hsat_pkg::acc_t   base_s3 [3];
	logic             accept;
	logic             inv_s2;

	assign busy      = 1'b0;
	assign cfg_ready = 1'b1;
	assign accept    = start & ~busy;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frame_pair_q <= '0;
			rot_q[0]     <= '0;
			rot_q[1]     <= '0;
			rot_q[2]     <= '0;
			scale_q      <= '0;
			shift_q[0]   <= '0;
			shift_q[1]   <= '0;
			shift_q[2]   <= '0;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				hsat_pkg::REG_FRAME_PAIR: begin
					frame_pair_q <= cfg_data[2*hsat_pkg::FRAME_W-1:0];
				end
				hsat_pkg::REG_ROT_X: begin
					rot_q[0] <= cfg_data;
				end
				hsat_pkg::REG_ROT_Y: begin
					rot_q[1] <= cfg_data;
				end
				hsat_pkg::REG_ROT_Z: begin
					rot_q[2] <= cfg_data;
				end
				hsat_pkg::REG_SCALE_DELTA: begin
					scale_q <= cfg_data;
				end
				hsat_pkg::REG_SHIFT_X: begin
					shift_q[0] <= cfg_data[hsat_pkg::SHIFT_W-1:0];
				end
				hsat_pkg::REG_SHIFT_Y: begin
					shift_q[1] <= cfg_data[hsat_pkg::SHIFT_W-1:0];
				end
				hsat_pkg::REG_SHIFT_Z: begin
					shift_q[2] <= cfg_data[hsat_pkg::SHIFT_W-1:0];
				end
				default: begin
				end
			endcase
		end
	end

	// from-frame wins when both ids match
	always_comb begin
		ctl_d.vld = accept;
		if (cmd.src_frame == frame_pair_q[hsat_pkg::FRAME_W-1:0]) begin
			ctl_d.dir = hsat_pkg::DIR_FWD;
		end else if (cmd.src_frame == frame_pair_q[2*hsat_pkg::FRAME_W-1:hsat_pkg::FRAME_W]) begin
			ctl_d.dir = hsat_pkg::DIR_INV;
		end else begin
			ctl_d.dir = hsat_pkg::DIR_NONE;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s1 <= '0;
			ctl_s2 <= '0;
			ctl_s3 <= '0;
		end else begin
			ctl_s1 <= ctl_d;
			ctl_s2 <= ctl_s1;
			ctl_s3 <= ctl_s2;
		end
	end

	always_ff @(posedge clk) begin
		v_s1[0] <= cmd.in_x;
		v_s1[1] <= cmd.in_y;
		v_s1[2] <= cmd.in_z;
	end

	assign inv_s2 = (ctl_s2.dir == hsat_pkg::DIR_INV);

	// one lane per axis: scale product, inverse pre-subtraction
	for (genvar i = 0; i < 3; i++) begin : g_lane
		hsat_lane u_lane (
			.clk     (clk),
			.v       (v_s1[i]),
			.inv     (inv_s2),
			.scale   (scale_q),
			.shift   (shift_q[i]),
			.u_s3    (u_s3[i]),
			.base_s3 (base_s3[i])
		);
	end

	// rotation cross terms mix the axes, then round and clamp
	hsat_merge u_merge (
		.clk     (clk),
		.arst_n  (arst_n),
		.ctl_s3  (ctl_s3),
		.u_s3    (u_s3),
		.base_s3 (base_s3),
		.rot     (rot_q),
		.done    (done),
		.res     (res)
	);

endmodule

### rtl/core/hsat_check.sv
// ----------------------------------------------------------------------------
// hsat_check: port-level checks for the Helmert transform
// Latency, mismatch result and saturation bound, bound to the top level.
// ----------------------------------------------------------------------------
module hsat_check (
	input logic                clk,
	input logic                arst_n,
	input logic                start,
	input logic                busy,
	input logic                done,
	input hsat_pkg::out_word_t res
);

	// every accepted word comes out after the fixed latency
	a_latency_out: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |-> ##(hsat_pkg::PIPE_DEPTH) done)
		else $error("accepted word did not come out on time");

	// no word appears without an acceptance before it
	a_latency_in: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(start && !busy, hsat_pkg::PIPE_DEPTH))
		else $error("result word without a matching start");

	a_mismatch_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(done && res.direction == hsat_pkg::DIR_NONE) |->
		(res.out_x == '0 && res.out_y == '0 && res.out_z == '0 && !res.saturated))
		else $error("frame mismatch result not zero");

	a_sat_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(done && res.saturated) |->
		(res.out_x == hsat_pkg::COORD_MAX || res.out_x == hsat_pkg::COORD_MIN ||
		res.out_y == hsat_pkg::COORD_MAX || res.out_y == hsat_pkg::COORD_MIN ||
		res.out_z == hsat_pkg::COORD_MAX || res.out_z == hsat_pkg::COORD_MIN))
		else $error("saturated flag without a clamped coordinate");

endmodule

bind helmert_small_angle_transform hsat_check u_hsat_check (
	.clk    (clk),
	.arst_n (arst_n),
	.start  (start),
	.busy   (busy),
	.done   (done),
	.res    (res)
);

### tb/helmert_small_angle_transform_tb.sv
// ----------------------------------------------------------------------------
// helmert_small_angle_transform_tb: self-checking bench for the Helmert block
// Directed corners, then random points under many frame, rotation, scale and
// shift settings. Every word is checked field by field against a local model.
// ----------------------------------------------------------------------------
module helmert_small_angle_transform_tb;

	timeunit 1ns;
	timeprecision 1ps;

	import hsat_pkg::*;

	localparam int CLK_PERIOD   = 10;
	localparam int RESET_CYCLES = 7;
	localparam int CYCLE_LIMIT  = 200000;
	localparam int IDLE_PCT     = 32;
	localparam int MAX_PRINTS   = 100;

	// documented ranges of the parameter registers
	localparam int ROT_LIM   = 1099511628;   // 1e-3 rad * 2^40
	localparam int SCALE_LIM = 1073741824;   // 2^30
	localparam int SHIFT_LIM = 1000000000;   // 1e5 m in 0.1 mm

	// wide enough to hold every sum exactly
	typedef logic signed [127:0] wide_t;

	logic                  clk = 1'b0;
	logic                  arst_n;
	logic                  start;
	logic                  busy;
	in_word_t              cmd;
	logic                  done;
	out_word_t             res;
	logic                  cfg_valid;
	logic                  cfg_ready;
	logic [REG_IDX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;

	// shadow copy of the parameter registers
	logic [15:0]  frame_pair_q;
	rot_t         rot_q [3];
	rot_t         scale_q;
	shift_t       shift_q [3];

	out_word_t    transformed_q [$];
	int unsigned  mismatches = 0;
	int unsigned  cycle_count = 0;
	bit           gaps_on;

	helmert_small_angle_transform i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.busy      (busy),
		.cmd       (cmd),
		.done      (done),
		.res       (res),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	always #(CLK_PERIOD/2) clk = ~clk;

	// watchdog: a hung handshake or a lost word ends the run here
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("FAILURE");
			$finish;
		end
	end

	// ------------------------------------------------------------------------
	// Model of the transform
	// ------------------------------------------------------------------------

	// round to nearest, halves toward +inf: floor((a + 2^(F-1)) / 2^F)
	function automatic wide_t round_frac(input wide_t a);
		return (a + (wide_t'(1) <<< (FRAC_BITS - 1))) >>> FRAC_BITS;
	endfunction

	function automatic out_word_t transform_point(input in_word_t p);
		wide_t     v [3];
		wide_t     w [3];
		wide_t     t [3];
		wide_t     acc [3];
		wide_t     q;
		wide_t     rx, ry, rz, s;
		coord_t    c [3];
		out_word_t r;
		r = '0;
		r.direction = DIR_NONE;
		v[0] = wide_t'(p.in_x);
		v[1] = wide_t'(p.in_y);
		v[2] = wide_t'(p.in_z);
		rx = wide_t'(rot_q[0]);
		ry = wide_t'(rot_q[1]);
		rz = wide_t'(rot_q[2]);
		s  = wide_t'(scale_q);
		for (int i = 0; i < 3; i++) t[i] = wide_t'(shift_q[i]);

		// from-frame wins when both ids are equal
		if (p.src_frame == frame_pair_q[7:0]) begin
			for (int i = 0; i < 3; i++)
				acc[i] = (v[i] <<< FRAC_BITS) + s * v[i] + (t[i] <<< FRAC_BITS);
			acc[0] = acc[0] + ry * v[2] - rz * v[1];
			acc[1] = acc[1] + rz * v[0] - rx * v[2];
			acc[2] = acc[2] + rx * v[1] - ry * v[0];
			r.direction = DIR_FWD;
		end else if (p.src_frame == frame_pair_q[15:8]) begin
			// scale and shift are undone first, with s*v rounded, then R^T applied
			for (int i = 0; i < 3; i++)
				w[i] = v[i] - round_frac(s * v[i]) - t[i];
			acc[0] = (w[0] <<< FRAC_BITS) + rz * w[1] - ry * w[2];
			acc[1] = (w[1] <<< FRAC_BITS) + rx * w[2] - rz * w[0];
			acc[2] = (w[2] <<< FRAC_BITS) + ry * w[0] - rx * w[1];
			r.direction = DIR_INV;
		end else begin
			return r;
		end

		for (int i = 0; i < 3; i++) begin
			q = round_frac(acc[i]);
			if (q < wide_t'(COORD_MIN)) begin
				q = wide_t'(COORD_MIN);
				r.saturated = 1'b1;
			end else if (q > wide_t'(COORD_MAX)) begin
				q = wide_t'(COORD_MAX);
				r.saturated = 1'b1;
			end
			c[i] = q[COORD_BITS-1:0];
		end
		r.out_x = c[0];
		r.out_y = c[1];
		r.out_z = c[2];
		return r;
	endfunction

	// ------------------------------------------------------------------------
	// Checking
	// ------------------------------------------------------------------------

	task automatic report_mismatch(input string what, input longint got,
		input longint want);
		if (mismatches < MAX_PRINTS)
			$display("%0t: %0s mismatch: got %0d, expected %0d", $realtime, what,
				got, want);
		mismatches++;
	endtask

	// no backpressure: every done cycle is a word, checked in arrival order
	always @(posedge clk) begin
		out_word_t want;
		if (arst_n && done) begin
			if (transformed_q.size() == 0) begin
				report_mismatch("unexpected word, out_x", longint'(res.out_x), 0);
			end else begin
				want = transformed_q.pop_front();
				if (res.out_x !== want.out_x)
					report_mismatch("out_x", longint'(res.out_x),
						longint'(want.out_x));
				if (res.out_y !== want.out_y)
					report_mismatch("out_y", longint'(res.out_y),
						longint'(want.out_y));
				if (res.out_z !== want.out_z)
					report_mismatch("out_z", longint'(res.out_z),
						longint'(want.out_z));
				if (res.direction !== want.direction)
					report_mismatch("direction", longint'(res.direction),
						longint'(want.direction));
				if (res.saturated !== want.saturated)
					report_mismatch("saturated", longint'(res.saturated),
						longint'(want.saturated));
			end
		end
	end

	// ------------------------------------------------------------------------
	// Stimulus helpers
	// ------------------------------------------------------------------------

	function automatic coord_t rand_coord();
		logic [63:0] bits;
		int          k;
		coord_t      c;
		bits = {$urandom, $urandom};
		case ($urandom_range(3))
			0: begin
				c = bits[COORD_BITS-1:0];
			end
			1: begin
				k = $urandom_range(65535);
				c = coord_t'(k - 32768);
			end
			2: begin
				k = $urandom_range(1000);
				c = $urandom_range(1) ? COORD_MAX - coord_t'(k) : COORD_MIN + coord_t'(k);
			end
			default: begin
				c = coord_t'($signed(bits[27:0]));
			end
		endcase
		return c;
	endfunction

	function automatic in_word_t make_point(input coord_t x, input coord_t y,
		input coord_t z, input logic [FRAME_W-1:0] src);
		in_word_t p;
		p.in_x = x;
		p.in_y = y;
		p.in_z = z;
		p.src_frame = src;
		return p;
	endfunction

	// signed value in [-lim, lim]
	function automatic logic [31:0] rand_span(input int lim);
		int k;
		k = $urandom_range(lim);
		return $urandom_range(1) ? -k : k;
	endfunction

	// start stays high between back-to-back words; lowered in gaps and while the pipe drains
	task automatic send_point(input in_word_t p);
		while (gaps_on && $urandom_range(99) < IDLE_PCT) begin
			start <= 1'b0;
			cmd   <= make_point(rand_coord(), rand_coord(), rand_coord(),
				FRAME_W'($urandom));
			@(posedge clk);
		end
		start <= 1'b1;
		cmd   <= p;
		do @(posedge clk); while (busy);
		transformed_q.push_back(transform_point(p));
	endtask

	task automatic write_reg(input logic [REG_IDX_W-1:0] idx,
		input logic [CFG_DATA_W-1:0] data);
		while (gaps_on && $urandom_range(99) < IDLE_PCT) begin
			cfg_valid <= 1'b0;
			cfg_index <= REG_IDX_W'($urandom);
			cfg_data  <= $urandom;
			@(posedge clk);
		end
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		do @(posedge clk); while (!cfg_ready);
		case (idx)
			REG_FRAME_PAIR:  frame_pair_q = data[15:0];
			REG_ROT_X:       rot_q[0]     = data;
			REG_ROT_Y:       rot_q[1]     = data;
			REG_ROT_Z:       rot_q[2]     = data;
			REG_SCALE_DELTA: scale_q      = data;
			REG_SHIFT_X:     shift_q[0]   = data[SHIFT_W-1:0];
			REG_SHIFT_Y:     shift_q[1]   = data[SHIFT_W-1:0];
			REG_SHIFT_Z:     shift_q[2]   = data[SHIFT_W-1:0];
			default: ;
		endcase
	endtask

	// config takes effect at once, so the pipe must be empty first
	task automatic wait_results_flushed();
		start <= 1'b0;
		while (transformed_q.size() != 0) @(posedge clk);
	endtask

	task automatic load_config(input logic [15:0] pair, input logic [31:0] rx,
		input logic [31:0] ry, input logic [31:0] rz, input logic [31:0] sc,
		input logic [31:0] tx, input logic [31:0] ty, input logic [31:0] tz);
		wait_results_flushed();
		write_reg(REG_FRAME_PAIR, pair);
		write_reg(REG_ROT_X, rx);
		write_reg(REG_ROT_Y, ry);
		write_reg(REG_ROT_Z, rz);
		write_reg(REG_SCALE_DELTA, sc);
		write_reg(REG_SHIFT_X, tx);
		write_reg(REG_SHIFT_Y, ty);
		write_reg(REG_SHIFT_Z, tz);
		cfg_valid <= 1'b0;
	endtask

	// ------------------------------------------------------------------------
	// Tests
	// ------------------------------------------------------------------------

	// all registers zero: frame 0 maps to itself, any other frame misses
	task automatic test_reset_defaults();
		send_point(make_point(COORD_MAX, COORD_MIN, '0, 8'h00));
		send_point(make_point(coord_t'(-1), coord_t'(1), coord_t'(12345), 8'h00));
		send_point(make_point(COORD_MAX, COORD_MAX, COORD_MAX, 8'h05));
	endtask

	// every parameter at its positive limit: full-range and small points in both directions, and a frame miss
	task automatic test_upper_limits();
		load_config(16'hC33C, ROT_LIM, ROT_LIM, ROT_LIM, SCALE_LIM,
			SHIFT_LIM, SHIFT_LIM, SHIFT_LIM);
		send_point(make_point(COORD_MAX, COORD_MAX, COORD_MAX, 8'h3C));
		send_point(make_point(COORD_MIN, COORD_MIN, COORD_MIN, 8'h3C));
		send_point(make_point(COORD_MAX, COORD_MAX, COORD_MAX, 8'hC3));
		send_point(make_point(COORD_MIN, COORD_MIN, COORD_MIN, 8'hC3));
		send_point(make_point(coord_t'(1), coord_t'(-1), '0, 8'h3C));
		send_point(make_point(coord_t'(1), coord_t'(-1), '0, 8'hC3));
		send_point(make_point(COORD_MAX, COORD_MIN, coord_t'(7), 8'h00));
	endtask

	task automatic test_lower_limits();
		load_config(16'hFF00, -ROT_LIM, -ROT_LIM, -ROT_LIM, -SCALE_LIM,
			-SHIFT_LIM, -SHIFT_LIM, -SHIFT_LIM);
		send_point(make_point(COORD_MAX, COORD_MIN, COORD_MAX, 8'h00));
		send_point(make_point(COORD_MIN, COORD_MAX, COORD_MIN, 8'h00));
		send_point(make_point(COORD_MAX, COORD_MIN, COORD_MAX, 8'hFF));
		send_point(make_point(COORD_MIN, COORD_MAX, COORD_MIN, 8'hFF));
	endtask

	// from-frame and to-frame equal: forward wins
	task automatic test_equal_frame_ids();
		load_config(16'h7777, rand_span(ROT_LIM), rand_span(ROT_LIM),
			rand_span(ROT_LIM), rand_span(SCALE_LIM), rand_span(SHIFT_LIM),
			rand_span(SHIFT_LIM), rand_span(SHIFT_LIM));
		send_point(make_point(rand_coord(), rand_coord(), rand_coord(), 8'h77));
		send_point(make_point(rand_coord(), rand_coord(), rand_coord(), 8'h76));
	endtask

	// rotations and scale far past 1e-3, shifts with a stray bit 31.
	// scale -2^31 with +-768 lands s*v exactly on a half: ties go up.
	task automatic test_oversized_params();
		load_config(16'h0201, 32'h7FFF_FFFF, 32'h8000_0000, 32'h4000_0000,
			32'h8000_0000, 32'hBFFF_FFFF, 32'h4000_0000, 32'h7FFF_FFFF);
		send_point(make_point(coord_t'(768), coord_t'(-768), coord_t'(1), 8'h02));
		send_point(make_point(coord_t'(768), coord_t'(-768), coord_t'(1), 8'h01));
		send_point(make_point(COORD_MAX, COORD_MAX, COORD_MIN, 8'h01));
		send_point(make_point(COORD_MIN, COORD_MIN, COORD_MAX, 8'h02));
	endtask

	// random settings per phase; most points hit one of the two frames
	task automatic test_random_traffic();
		logic [7:0] from_id, to_id, src;
		for (int phase = 0; phase < 8; phase++) begin
			from_id = 8'($urandom);
			to_id   = ($urandom_range(7) == 0) ? from_id : 8'($urandom);
			gaps_on = (phase != 2);   // one long back-to-back stretch
			case (phase % 4)
				0: load_config({to_id, from_id}, rand_span(ROT_LIM), rand_span(ROT_LIM),
					rand_span(ROT_LIM), rand_span(SCALE_LIM), rand_span(SHIFT_LIM),
					rand_span(SHIFT_LIM), rand_span(SHIFT_LIM));
				1: load_config({to_id, from_id}, $urandom, $urandom, $urandom,
					$urandom, $urandom, $urandom, $urandom);
				2: load_config({to_id, from_id}, rand_span(1000), rand_span(1000),
					rand_span(1000), rand_span(1000), rand_span(1000),
					rand_span(1000), rand_span(1000));
				default: load_config({to_id, from_id},
					$urandom_range(1) ? ROT_LIM : -ROT_LIM,
					$urandom_range(1) ? ROT_LIM : -ROT_LIM,
					$urandom_range(1) ? ROT_LIM : -ROT_LIM,
					$urandom_range(1) ? SCALE_LIM : -SCALE_LIM,
					$urandom_range(1) ? SHIFT_LIM : -SHIFT_LIM,
					$urandom_range(1) ? SHIFT_LIM : -SHIFT_LIM,
					$urandom_range(1) ? SHIFT_LIM : -SHIFT_LIM);
			endcase
			for (int n = 0; n < 75; n++) begin
				// sender holds off mid-phase until the pipe has drained
				if (phase == 4 && n == 40) wait_results_flushed();
				case ($urandom_range(9))
					0, 1, 2, 3: src = from_id;
					4, 5, 6, 7, 8: src = to_id;
					default: src = 8'($urandom);
				endcase
				send_point(make_point(rand_coord(), rand_coord(), rand_coord(), src));
			end
		end
		gaps_on = 1'b1;
	endtask

	// ------------------------------------------------------------------------
	// Main sequence
	// ------------------------------------------------------------------------

	initial begin
		arst_n       = 1'b0;
		start        = 1'b0;
		cmd          = '0;
		cfg_valid    = 1'b0;
		cfg_index    = '0;
		cfg_data     = '0;
		gaps_on      = 1'b1;
		frame_pair_q = '0;
		scale_q      = '0;
		for (int i = 0; i < 3; i++) begin
			rot_q[i]   = '0;
			shift_q[i] = '0;
		end

		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_reset_defaults();
		test_upper_limits();
		test_lower_limits();
		test_equal_frame_ids();
		test_oversized_params();
		test_random_traffic();

		wait_results_flushed();
		// catch any stray word the block emits after the last expected one
		repeat (PIPE_DEPTH + 4) @(posedge clk);

		if (mismatches == 0) begin
			$display("SUCCESS");
		end else begin
			$display("FAILURE");
		end
		$finish;
	end

endmodule
